// ===== hw/rtl/pfb_pkg.sv =====
// Shared types and constants for the page framebuffer draw engine.
// Used by pfb_store, pfb_seq and the top level; depends on nothing.
package pfb_pkg;

  localparam int PAGE_ROWS = 8;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_PIXEL  = 3'd1,
    REQ_HRUN   = 3'd2,
    REQ_VRUN   = 3'd3,
    REQ_INVERT = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ACC_READ = 2'd0,
    ACC_OR   = 2'd1,
    ACC_XOR  = 2'd2,
    ACC_ZERO = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_FINISH = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic    en;
    acc_op_t op;
    logic [7:0] mask;
  } acc_ctrl_t;

endpackage

// ===== hw/rtl/pfb_store.sv =====
// Frame store memory with a registered read and a read-modify-write stage.
// Depends on pfb_pkg for the access control struct and operation codes.
// Driven by pfb_seq; each OR or XOR access reads its byte and writes it back in the next cycle.
module pfb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  pfb_pkg::acc_ctrl_t acc,
  input  logic [AW-1:0]     addr,
  output logic [7:0]        rdata
);

  logic [7:0]         mem [DEPTH];
  logic               wb_valid;
  pfb_pkg::acc_op_t   wb_op;
  logic [AW-1:0]      wb_addr;
  logic [7:0]         wb_mask;
  logic [7:0]         wb_data;

  always_ff @(posedge clk) begin
    if (acc.en && acc.op != pfb_pkg::ACC_ZERO) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= acc.en;
    end
  end

  always_ff @(posedge clk) begin
    wb_op   <= acc.op;
    wb_addr <= addr;
    wb_mask <= acc.mask;
  end

  always_comb begin
    case (wb_op)
      pfb_pkg::ACC_OR:   wb_data = rdata | wb_mask;
      pfb_pkg::ACC_XOR:  wb_data = rdata ^ wb_mask;
      pfb_pkg::ACC_ZERO: wb_data = 8'h00;
      default:           wb_data = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wb_valid && wb_op != pfb_pkg::ACC_READ) begin
      mem[wb_addr] <= wb_data;
    end
  end

  // A sweep never revisits an address, so a read never meets a pending write to it.
  a_no_raw_overlap: assert property (@(posedge clk) disable iff (rst)
    acc.en && wb_valid && wb_op != pfb_pkg::ACC_READ |-> addr != wb_addr)
    else $error("read issued to the address being written back");

endmodule

// ===== hw/rtl/pfb_seq.sv =====
// Request decoder and access sequencer for the page framebuffer draw engine.
// Depends on pfb_pkg; drives pfb_store with one address per cycle during a sweep.
module pfb_seq #(
  parameter int WIDTH = 128,
  parameter int HEIGHT = 64,
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int NW = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [6:0]         column,
  input  logic [5:0]         row,
  input  logic [6:0]         span_start,
  input  logic [6:0]         span_end,
  output pfb_pkg::acc_ctrl_t acc,
  output logic [AW-1:0]      acc_addr,
  input  logic [7:0]         rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_data
);

  pfb_pkg::seq_state_t state, state_next;

  // Work registers of the current request.
  pfb_pkg::acc_op_t op;
  logic [AW-1:0]    addr;
  logic [NW-1:0]    remaining;
  logic             first;
  logic             step_page;
  logic             has_result;
  logic             is_read;
  logic [7:0]       mask_first;
  logic [7:0]       mask_mid;
  logic [7:0]       mask_last;

  // Decoded set-up of an incoming request.
  logic             s_run;
  pfb_pkg::acc_op_t s_op;
  logic [AW-1:0]    s_addr;
  logic [NW-1:0]    s_count;
  logic             s_step_page;
  logic             s_is_read;
  logic [7:0]       s_mask_first;
  logic [7:0]       s_mask_mid;
  logic [7:0]       s_mask_last;

  logic             row_ok;
  logic             col_ok;
  logic [7:0]       hs;
  logic [7:0]       he;
  logic [6:0]       vs;
  logic [6:0]       ve;
  logic [7:0]       row_bit;
  logic [7:0]       top_m;
  logic [7:0]       bot_m;
  logic [AW-1:0]    page_base;
  logic [AW-1:0]    vpage_base;

  always_comb begin
    row_ok  = 32'(row) < HEIGHT;
    col_ok  = 32'(column) < WIDTH;
    hs      = ({1'b0, span_start} > 8'(WIDTH - 1)) ? 8'(WIDTH - 1) : {1'b0, span_start};
    he      = ({1'b0, span_end} > 8'(WIDTH - 1)) ? 8'(WIDTH - 1) : {1'b0, span_end};
    vs      = (span_start > 7'(HEIGHT - 1)) ? 7'(HEIGHT - 1) : span_start;
    ve      = (span_end > 7'(HEIGHT - 1)) ? 7'(HEIGHT - 1) : span_end;
    row_bit = 8'h01 << row[2:0];
    top_m   = 8'hFF << vs[2:0];
    bot_m   = 8'hFF >> (3'd7 - ve[2:0]);
    page_base  = AW'(row[5:3]) * AW'(WIDTH);
    vpage_base = AW'(vs[5:3]) * AW'(WIDTH);

    s_run        = 1'b0;
    s_op         = pfb_pkg::ACC_READ;
    s_addr       = '0;
    s_count      = NW'(1);
    s_step_page  = 1'b0;
    s_is_read    = 1'b0;
    s_mask_first = 8'hFF;
    s_mask_mid   = 8'hFF;
    s_mask_last  = 8'hFF;

    case (pfb_pkg::req_t'(req_type))
      pfb_pkg::REQ_CLEAR: begin
        s_run   = 1'b1;
        s_op    = pfb_pkg::ACC_ZERO;
        s_count = NW'(DEPTH);
      end
      pfb_pkg::REQ_PIXEL: begin
        s_run        = col_ok && row_ok;
        s_op         = pfb_pkg::ACC_OR;
        s_addr       = page_base + AW'(column);
        s_mask_first = row_bit;
      end
      pfb_pkg::REQ_HRUN: begin
        s_run        = row_ok && (he >= hs);
        s_op         = pfb_pkg::ACC_OR;
        s_addr       = page_base + AW'(hs);
        s_count      = NW'(he - hs) + NW'(1);
        s_mask_first = row_bit;
        s_mask_mid   = row_bit;
        s_mask_last  = row_bit;
      end
      pfb_pkg::REQ_VRUN: begin
        s_run        = col_ok && (ve >= vs);
        s_op         = pfb_pkg::ACC_OR;
        s_addr       = vpage_base + AW'(column);
        s_count      = NW'(ve[5:3] - vs[5:3]) + NW'(1);
        s_step_page  = 1'b1;
        // A run inside a single page keeps only the rows both masks cover.
        s_mask_first = (vs[5:3] == ve[5:3]) ? (top_m & bot_m) : top_m;
        s_mask_last  = bot_m;
      end
      pfb_pkg::REQ_INVERT: begin
        s_run   = 1'b1;
        s_op    = pfb_pkg::ACC_XOR;
        s_count = NW'(DEPTH);
      end
      pfb_pkg::REQ_READ: begin
        s_run     = col_ok && row_ok;
        s_op      = pfb_pkg::ACC_READ;
        s_addr    = page_base + AW'(column);
        s_is_read = col_ok && row_ok;
      end
      default: begin
        s_run = 1'b0;
      end
    endcase
  end

  // Reset starts a clearing sweep of the whole store that returns no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfb_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = s_run ? pfb_pkg::ST_RUN : pfb_pkg::ST_FINISH;
        end
      end
      pfb_pkg::ST_RUN: begin
        if (remaining == NW'(1)) begin
          state_next = pfb_pkg::ST_FINISH;
        end
      end
      pfb_pkg::ST_FINISH: begin
        if (!has_result || res_ready) begin
          state_next = pfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == pfb_pkg::ST_IDLE);
    acc.en    = (state == pfb_pkg::ST_RUN);
    acc.op    = op;
    if (first) begin
      acc.mask = mask_first;
    end else if (remaining == NW'(1)) begin
      acc.mask = mask_last;
    end else begin
      acc.mask = mask_mid;
    end
    acc_addr  = addr;
    res_valid = (state == pfb_pkg::ST_FINISH) && has_result;
    res_data  = is_read ? rdata : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= pfb_pkg::ACC_ZERO;
      addr       <= '0;
      remaining  <= NW'(DEPTH);
      first      <= 1'b1;
      step_page  <= 1'b0;
      has_result <= 1'b0;
      is_read    <= 1'b0;
      mask_first <= 8'hFF;
      mask_mid   <= 8'hFF;
      mask_last  <= 8'hFF;
    end else begin
      case (state)
        pfb_pkg::ST_IDLE: begin
          if (in_valid) begin
            op         <= s_op;
            addr       <= s_addr;
            remaining  <= s_count;
            first      <= 1'b1;
            step_page  <= s_step_page;
            has_result <= 1'b1;
            is_read    <= s_is_read;
            mask_first <= s_mask_first;
            mask_mid   <= s_mask_mid;
            mask_last  <= s_mask_last;
          end
        end
        pfb_pkg::ST_RUN: begin
          addr      <= addr + (step_page ? AW'(WIDTH) : AW'(1));
          remaining <= remaining - NW'(1);
          first     <= 1'b0;
        end
        default: begin
          first <= first;
        end
      endcase
    end
  end

  a_run_count_live: assert property (@(posedge clk) disable iff (rst)
    state == pfb_pkg::ST_RUN |-> remaining != '0)
    else $error("sweep running with no accesses left");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != pfb_pkg::ST_IDLE && has_result)
    else $error("accepted request did not start");

endmodule

// ===== hw/rtl/page_framebuffer_draw_engine.sv =====
// Page framebuffer draw engine: one request in, one read_data result out.
// The store is accessed once for pixel and read, once per byte of a row run, once per page for
// a column run and once per byte (WIDTH*pages) for clear and invert; none when nothing is touched.
// One request at a time; the next is accepted when the last has finished (single store port).
// Reset (rst, synchronous) clears the store in a sweep of all WIDTH*pages bytes; in_ready stays
// low until that sweep ends. The result register lets the next request start.
module page_framebuffer_draw_engine #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [6:0] column,
  input  logic [5:0] row,
  input  logic [6:0] span_start,
  input  logic [6:0] span_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  localparam int PAGES = (HEIGHT + pfb_pkg::PAGE_ROWS - 1) / pfb_pkg::PAGE_ROWS;
  localparam int DEPTH = WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  pfb_pkg::acc_ctrl_t acc;
  logic [AW-1:0]      acc_addr;
  logic [7:0]         rdata;
  logic               res_valid;
  logic               res_ready;
  logic [7:0]         res_data;

  pfb_seq #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .DEPTH  (DEPTH),
    .AW     (AW),
    .NW     (NW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .column     (column),
    .row        (row),
    .span_start (span_start),
    .span_end   (span_end),
    .acc        (acc),
    .acc_addr   (acc_addr),
    .rdata      (rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  pfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .addr  (acc_addr),
    .rdata (rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_data <= res_data;
    end
  end

  // A finished result that cannot move on must still be offered next cycle.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("finished result dropped while the output was full");

endmodule

// ===== verif/pfb_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the page framebuffer draw engine: keeps a shadow frame store,
// predicts read_data for every accepted request and compares each result in order.
// Depends on pfb_pkg for the request codes and the page height.
module pfb_checker #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [6:0] column,
  input  logic [5:0] row,
  input  logic [6:0] span_start,
  input  logic [6:0] span_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] read_data,
  output int         mismatches,
  output int         pending,
  output int         requests_seen,
  output int         reads_nonzero
);

  localparam int PAGES       = (HEIGHT + pfb_pkg::PAGE_ROWS - 1) / pfb_pkg::PAGE_ROWS;
  localparam int STORE_BYTES = WIDTH * PAGES;

  logic [7:0] shadow_store [STORE_BYTES];
  logic [7:0] expected_bytes [$];
  logic [7:0] want;
  int fail_count = 0;
  int req_count = 0;
  int lit_reads = 0;

  task automatic or_byte(input int page, input int col, input logic [7:0] mask);
    if (page < PAGES && col < WIDTH) begin
      shadow_store[page * WIDTH + col] = shadow_store[page * WIDTH + col] | mask;
    end
  endtask

  // Applies one request to the shadow store and returns the byte it should produce.
  task automatic predict_request(input logic [2:0] kind, input logic [6:0] col,
                                 input logic [5:0] y, input logic [6:0] first,
                                 input logic [6:0] last, output logic [7:0] rd);
    int s;
    int e;
    int sp;
    int ep;
    logic [7:0] top;
    logic [7:0] bot;
    rd = 8'h00;
    case (kind)
      pfb_pkg::REQ_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      end
      pfb_pkg::REQ_PIXEL: begin
        if (col < WIDTH && y < HEIGHT) begin
          or_byte(y / pfb_pkg::PAGE_ROWS, col, 8'h01 << (y % pfb_pkg::PAGE_ROWS));
        end
      end
      pfb_pkg::REQ_HRUN: begin
        if (y < HEIGHT) begin
          s = (first > WIDTH - 1) ? WIDTH - 1 : first;
          e = (last > WIDTH - 1) ? WIDTH - 1 : last;
          for (int i = s; i <= e; i++) begin
            or_byte(y / pfb_pkg::PAGE_ROWS, i, 8'h01 << (y % pfb_pkg::PAGE_ROWS));
          end
        end
      end
      pfb_pkg::REQ_VRUN: begin
        if (col < WIDTH) begin
          s = (first > HEIGHT - 1) ? HEIGHT - 1 : first;
          e = (last > HEIGHT - 1) ? HEIGHT - 1 : last;
          if (e >= s) begin
            sp  = s / pfb_pkg::PAGE_ROWS;
            ep  = e / pfb_pkg::PAGE_ROWS;
            top = 8'hFF << (s % pfb_pkg::PAGE_ROWS);
            bot = 8'hFF >> (pfb_pkg::PAGE_ROWS - 1 - e % pfb_pkg::PAGE_ROWS);
            // A run that starts and ends in one page only sets the rows both masks share.
            if (sp == ep) begin
              or_byte(sp, col, top & bot);
            end else begin
              or_byte(sp, col, top);
              for (int p = sp + 1; p < ep; p++) or_byte(p, col, 8'hFF);
              or_byte(ep, col, bot);
            end
          end
        end
      end
      pfb_pkg::REQ_INVERT: begin
        foreach (shadow_store[i]) shadow_store[i] = ~shadow_store[i];
      end
      pfb_pkg::REQ_READ: begin
        if (col < WIDTH && y < HEIGHT) begin
          rd = shadow_store[(y / pfb_pkg::PAGE_ROWS) * WIDTH + col];
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      expected_bytes.delete();
    end else begin
      // Results are matched before new requests are queued so that a stray result
      // can never pair with the request accepted on the same edge.
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          note_failure($sformatf("result with no request waiting: read_data=%02h", read_data));
        end else begin
          want = expected_bytes.pop_front();
          if (read_data !== want) begin
            note_failure($sformatf("read_data mismatch: expected %02h, got %02h",
                                   want, read_data));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_request(req_type, column, row, span_start, span_end, want);
        expected_bytes.push_back(want);
        req_count++;
        if (req_type == pfb_pkg::REQ_READ && want != 8'h00) lit_reads++;
      end
    end
    mismatches    <= fail_count;
    pending       <= expected_bytes.size();
    requests_seen <= req_count;
    reads_nonzero <= lit_reads;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the page framebuffer draw engine testbench: clock, reset, request stimulus
// with idle phases, result back-pressure and the verdict.
// Depends on pfb_pkg, page_framebuffer_draw_engine and pfb_checker.
module testbench;

  localparam int WIDTH          = 128;
  localparam int HEIGHT         = 64;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int PHASE_ITEMS    = 180;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [2:0] req_type   = 3'd0;
  logic [6:0] column     = 7'd0;
  logic [5:0] row        = 6'd0;
  logic [6:0] span_start = 7'd0;
  logic [6:0] span_end   = 7'd0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] read_data;

  int mismatches;
  int pending;
  int requests_seen;
  int reads_nonzero;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit stall_burst   = 1'b0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  page_framebuffer_draw_engine #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .column(column), .row(row),
    .span_start(span_start), .span_end(span_end),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data)
  );

  pfb_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .column(column), .row(row),
    .span_start(span_start), .span_end(span_end),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
    .mismatches(mismatches), .pending(pending),
    .requests_seen(requests_seen), .reads_nonzero(reads_nonzero)
  );

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_burst && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic [2:0] kind, input logic [6:0] col, input logic [5:0] y,
                          input logic [6:0] first, input logic [6:0] last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    column     <= col;
    row        <= y;
    span_start <= first;
    span_end   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Full sweeps are rare since each one walks the whole store.
  task automatic random_request();
    int pick;
    int tail;
    logic [2:0] kind;
    logic [6:0] col;
    logic [5:0] y;
    logic [6:0] first;
    logic [6:0] last;
    pick  = $urandom_range(199);
    col   = 7'($urandom_range(127));
    y     = 6'($urandom_range(63));
    first = 7'($urandom_range(127));
    last  = 7'($urandom_range(127));
    if (pick < 2) begin
      kind = pfb_pkg::REQ_CLEAR;
    end else if (pick < 4) begin
      kind = pfb_pkg::REQ_INVERT;
    end else if (pick < 6) begin
      kind = pick[0] ? REQ_SPARE7 : REQ_SPARE6;
    end else if (pick < 60) begin
      kind = pfb_pkg::REQ_PIXEL;
    end else if (pick < 95) begin
      kind = pfb_pkg::REQ_HRUN;
      if ($urandom_range(9) < 7) begin
        tail = first + $urandom_range(20);
        last = (tail > 127) ? 7'd127 : 7'(tail);
      end
    end else if (pick < 130) begin
      kind = pfb_pkg::REQ_VRUN;
      if ($urandom_range(9) < 7) begin
        first = 7'($urandom_range(63));
        tail  = first + $urandom_range(24);
        last  = (tail > 127) ? 7'd127 : 7'(tail);
      end
    end else begin
      kind = pfb_pkg::REQ_READ;
    end
    send_req(kind, col, y, first, last);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, every request code, clamped, reversed and single-page runs.
    send_req(pfb_pkg::REQ_READ,   7'd0,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_PIXEL,  7'd0,   6'd0,  7'd127, 7'd127);
    send_req(pfb_pkg::REQ_PIXEL,  7'd127, 6'd63, 7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd0,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd127, 6'd63, 7'd0,   7'd0);
    send_req(pfb_pkg::REQ_HRUN,   7'd0,   6'd9,  7'd0,   7'd127);
    send_req(pfb_pkg::REQ_HRUN,   7'd0,   6'd20, 7'd5,   7'd3);
    send_req(pfb_pkg::REQ_HRUN,   7'd0,   6'd30, 7'd127, 7'd127);
    send_req(pfb_pkg::REQ_VRUN,   7'd3,   6'd0,  7'd0,   7'd63);
    send_req(pfb_pkg::REQ_VRUN,   7'd4,   6'd0,  7'd3,   7'd5);
    send_req(pfb_pkg::REQ_VRUN,   7'd5,   6'd0,  7'd100, 7'd127);
    send_req(pfb_pkg::REQ_VRUN,   7'd6,   6'd0,  7'd50,  7'd10);
    send_req(pfb_pkg::REQ_VRUN,   7'd7,   6'd0,  7'd60,  7'd127);
    send_req(pfb_pkg::REQ_VRUN,   7'd8,   6'd0,  7'd2,   7'd21);
    send_req(pfb_pkg::REQ_READ,   7'd4,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd5,   6'd63, 7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd8,   6'd17, 7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd64,  6'd9,  7'd0,   7'd0);
    send_req(REQ_SPARE6,          7'd127, 6'd63, 7'd127, 7'd127);
    send_req(REQ_SPARE7,          7'd127, 6'd63, 7'd127, 7'd127);
    send_req(pfb_pkg::REQ_INVERT, 7'd0,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd4,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd100, 6'd40, 7'd0,   7'd0);
    send_req(pfb_pkg::REQ_CLEAR,  7'd0,   6'd0,  7'd0,   7'd0);
    send_req(pfb_pkg::REQ_READ,   7'd127, 6'd63, 7'd0,   7'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      repeat (PHASE_ITEMS) random_request();
    end

    // Long result hold-off while short requests keep coming, so the engine backs up.
    send_idle_pct = 0;
    stall_pct     = 0;
    stall_burst   = 1'b1;
    repeat (60) begin
      send_req($urandom_range(1) ? pfb_pkg::REQ_PIXEL : pfb_pkg::REQ_READ,
               7'($urandom_range(127)), 6'($urandom_range(63)),
               7'($urandom_range(127)), 7'($urandom_range(127)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d requests over four idle mixes and a %0d-cycle result hold-off;",
             requests_seen, HOLD_CYCLES);
    $display("%0d reads returned lit pixels, %0d mismatches.", reads_nonzero, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_store.sv
hw/rtl/pfb_seq.sv
hw/rtl/page_framebuffer_draw_engine.sv
verif/pfb_checker.sv
verif/testbench.sv
